@@ rtl/lpsd_pkg.sv @@
// Shared types and constants for the length-prefixed stream deframer.
// No dependencies; imported by every module of the block.
package lpsd_pkg;

    // Result kinds on the output tuser
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_BAD_LEN    = 2'd0;
    localparam logic [1:0] ERR_TOO_LARGE  = 2'd1;
    localparam logic [1:0] ERR_BAD_TYPE   = 2'd2;
    localparam logic [1:0] ERR_BAD_CHUNK  = 2'd3;

    // Frame classes
    localparam logic CLS_CONTROL = 1'b0;
    localparam logic CLS_CHUNK   = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_LEN    = 2'd0;
    localparam logic [1:0] CFG_CTRL_TYPE  = 2'd1;
    localparam logic [1:0] CFG_CHUNK_TYPE = 2'd2;

    // Configuration reset values
    localparam logic [31:0] MAX_LEN_RESET    = 32'd65536;
    localparam logic [7:0]  CTRL_TYPE_RESET  = 8'd1;
    localparam logic [7:0]  CHUNK_TYPE_RESET = 8'd2;

    // Chunk header layout (byte offsets inside the body)
    localparam logic [31:0] HDR_CHAIN_END = 32'd8;
    localparam logic [31:0] HDR_INDEX_END = 32'd12;
    localparam logic [31:0] HDR_BYTES     = 32'd16;

    // Output tdata width: 139 bits of fields padded to whole bytes
    localparam int TDATA_W = 144;

    // One queue entry: everything one input byte produces (up to two results)
    typedef struct packed {
        logic        has_pay;    // a payload byte result
        logic [7:0]  pay_byte;
        logic        pay_cls;
        logic        has_stat;   // a completion or error result
        logic        stat_err;   // 1 error, 0 frame complete
        logic        stat_cls;
        logic [63:0] chain_id;
        logic [31:0] chunk_index;
        logic [31:0] data_length;
        logic [1:0]  error_code;
    } t_entry;

endpackage

@@ rtl/length_prefixed_stream_deframer.sv @@
// Top level of the length-prefixed stream deframer.
// Depends on lpsd_pkg, lpsd_front, lpsd_queue and lpsd_back.
//
// Usage:
//  - Slave stream: one received byte per transfer in tdata[7:0]; tlast marks the
//    last byte of a receive batch.
//  - Master stream: one result per transfer. tuser holds the kind (payload byte,
//    frame complete, error); tlast marks the last result caused by one byte.
//  - Configuration channel: index 0 max frame length, 1 control type code,
//    2 chunk type code; always ready; user writes only while idle (not enforced).
//  - Throughput: one byte per cycle. A byte that ends a frame and also carries
//    payload gives two results, the payload byte first and then the status; the entry
//    queue absorbs that, so input stalls only when the queue fills.
//  - Path: a result is written into the queue, then loaded into the output
//    register, from which it is offered on the master side.
//  - Reset (synchronous, active low) empties the queue, clears the parser and
//    loads the default register values; no clearing pass is needed.
//  - When the receiver holds tready low, results wait in the output register
//    and queue; once QUEUE_DEPTH entries are waiting, the slave tready drops.
module length_prefixed_stream_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] data_byte
    input  logic                          i_s_axis_tlast,   // batch_end
    // master stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] payload_byte, [8] frame_class, [72:9] chain_id, [104:73] chunk_index,
    // [136:105] data_length, [138:137] error_code, [143:139] zero
    output logic [lpsd_pkg::TDATA_W-1:0]  o_m_axis_tdata,
    output logic [1:0]                    o_m_axis_tuser,   // [1:0] result_kind
    output logic                          o_m_axis_tlast,   // run_last
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import lpsd_pkg::*;

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    lpsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_byte   (i_s_axis_tdata),
        .i_in_last   (i_s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    lpsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    lpsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (head_entry),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

endmodule

@@ rtl/lpsd_front.sv @@
// Front part of the deframer: byte parser, configuration registers, result classification.
// Depends on lpsd_pkg; pushes one t_entry per byte that produces results.
module lpsd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_full,
    output logic                 o_push,
    output lpsd_pkg::t_entry     o_entry
);
    import lpsd_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2,
        PH_DROP = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_fl, n_fl;
    logic [31:0] r_body, n_body;          // L-1
    logic [31:0] r_body_m16, n_body_m16;  // L-17, expected chunk data length
    logic        r_short, n_short;        // body shorter than the chunk header
    logic [7:0]  r_type, n_type;
    logic [63:0] r_chain, n_chain;
    logic [31:0] r_idx, n_idx;
    logic [31:0] r_decl, n_decl;
    logic [31:0] r_max;
    logic [7:0]  r_ctrl_code;
    logic [7:0]  r_chunk_code;

    logic        accept;
    logic        do_finish;
    logic        bad_chunk;
    logic [7:0]  fin_type;
    logic [31:0] len_next;
    logic [31:0] cnt_inc;
    logic        body_ctrl;
    logic        body_chunk;
    t_entry      entry;

    assign o_in_ready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_full;
    assign len_next    = {r_fl[23:0], i_in_byte};
    assign cnt_inc     = r_cnt + 32'd1;
    assign body_ctrl   = (r_type == r_ctrl_code);
    assign body_chunk  = !body_ctrl && (r_type == r_chunk_code);

    // Parse step for one accepted byte
    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_fl       = r_fl;
        n_body     = r_body;
        n_body_m16 = r_body_m16;
        n_short    = r_short;
        n_type     = r_type;
        n_chain    = r_chain;
        n_idx      = r_idx;
        n_decl     = r_decl;
        entry      = '0;
        do_finish  = 1'b0;
        bad_chunk  = 1'b0;
        fin_type   = r_type;

        if (accept) begin
            case (r_phase)
                PH_LEN: begin
                    n_fl  = len_next;
                    n_cnt = cnt_inc;
                    if (r_cnt[1:0] == 2'd3) begin
                        n_cnt      = '0;
                        n_body     = len_next - 32'd1;
                        n_body_m16 = len_next - (HDR_BYTES + 32'd1);
                        n_short    = (len_next < (HDR_BYTES + 32'd1));
                        if (len_next == '0) begin
                            entry.has_stat   = 1'b1;
                            entry.stat_err   = 1'b1;
                            entry.error_code = ERR_BAD_LEN;
                            n_phase          = PH_DROP;
                        end else if (len_next > r_max) begin
                            entry.has_stat   = 1'b1;
                            entry.stat_err   = 1'b1;
                            entry.error_code = ERR_TOO_LARGE;
                            n_phase          = PH_DROP;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    n_type   = i_in_byte;
                    fin_type = i_in_byte;
                    n_cnt    = '0;
                    n_chain  = '0;
                    n_idx    = '0;
                    n_decl   = '0;
                    if (r_body == '0) begin
                        do_finish = 1'b1;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (body_ctrl) begin
                        entry.has_pay  = 1'b1;
                        entry.pay_byte = i_in_byte;
                        entry.pay_cls  = CLS_CONTROL;
                    end else if (body_chunk) begin
                        if (r_cnt < HDR_CHAIN_END) begin
                            n_chain = {r_chain[55:0], i_in_byte};
                        end else if (r_cnt < HDR_INDEX_END) begin
                            n_idx = {r_idx[23:0], i_in_byte};
                        end else if (r_cnt < HDR_BYTES) begin
                            n_decl = {r_decl[23:0], i_in_byte};
                        end else begin
                            entry.has_pay  = 1'b1;
                            entry.pay_byte = i_in_byte;
                            entry.pay_cls  = CLS_CHUNK;
                        end
                    end
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_body) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    // dropping: byte discarded
                end
            endcase

            // Frame end: validate and report
            if (do_finish) begin
                entry.has_stat = 1'b1;
                bad_chunk = r_short || (n_decl != r_body_m16) || (n_chain == '0) ||
                            (n_idx == '0) || (n_decl == '0);
                if (fin_type == r_ctrl_code) begin
                    entry.stat_cls    = CLS_CONTROL;
                    entry.data_length = r_body;
                    n_phase           = PH_LEN;
                    n_cnt             = '0;
                    n_fl              = '0;
                end else if (fin_type == r_chunk_code && !bad_chunk) begin
                    entry.stat_cls    = CLS_CHUNK;
                    entry.chain_id    = n_chain;
                    entry.chunk_index = n_idx;
                    entry.data_length = n_decl;
                    n_phase           = PH_LEN;
                    n_cnt             = '0;
                    n_fl              = '0;
                end else begin
                    entry.stat_err   = 1'b1;
                    entry.error_code = (fin_type == r_chunk_code) ? ERR_BAD_CHUNK
                                                                  : ERR_BAD_TYPE;
                    n_phase          = PH_DROP;
                end
            end

            // Batch end leaves the drop phase with clean state
            if (n_phase == PH_DROP && i_in_last) begin
                n_phase = PH_LEN;
                n_cnt   = '0;
                n_fl    = '0;
                n_type  = '0;
                n_chain = '0;
                n_idx   = '0;
                n_decl  = '0;
            end
        end
    end

    assign o_push  = accept && (entry.has_pay || entry.has_stat);
    assign o_entry = entry;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN;
            r_cnt      <= '0;
            r_fl       <= '0;
            r_body     <= '0;
            r_body_m16 <= '0;
            r_short    <= 1'b0;
            r_type     <= '0;
            r_chain    <= '0;
            r_idx      <= '0;
            r_decl     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_fl       <= n_fl;
            r_body     <= n_body;
            r_body_m16 <= n_body_m16;
            r_short    <= n_short;
            r_type     <= n_type;
            r_chain    <= n_chain;
            r_idx      <= n_idx;
            r_decl     <= n_decl;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= MAX_LEN_RESET;
            r_ctrl_code  <= CTRL_TYPE_RESET;
            r_chunk_code <= CHUNK_TYPE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_LEN:    r_max        <= i_cfg_data;
                CFG_CTRL_TYPE:  r_ctrl_code  <= i_cfg_data[7:0];
                CFG_CHUNK_TYPE: r_chunk_code <= i_cfg_data[7:0];
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // an error always leaves the parser dropping or back at the length prefix
    a_err_to_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_entry.has_stat && o_entry.stat_err |=>
        (r_phase == PH_DROP || r_phase == PH_LEN))
        else $error("error result without drop");
    // a byte never yields two results unless it also ends the frame
    a_pay_stat_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_entry.has_pay && o_entry.has_stat |-> r_phase == PH_BODY)
        else $error("double result outside body");
`endif

endmodule

@@ rtl/lpsd_queue.sv @@
// Short entry queue between the parser front and the output back part.
// Depends on lpsd_pkg for t_entry.
module lpsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lpsd_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output lpsd_pkg::t_entry     o_entry,
    output logic                 o_full,
    output logic                 o_empty
);
    import lpsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue underflow");
`endif

endmodule

@@ rtl/lpsd_back.sv @@
// Back part of the deframer: expands queue entries into output transfers.
// Depends on lpsd_pkg; drives the registered master-side stream.
module lpsd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpsd_pkg::t_entry              i_entry,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lpsd_pkg::TDATA_W-1:0]  o_data,
    output logic [1:0]                    o_user,
    output logic                          o_last
);
    import lpsd_pkg::*;

    logic                r_valid, n_valid;
    logic                r_second, n_second;   // payload sent, status pending
    logic [TDATA_W-1:0]  r_data, n_data;
    logic [1:0]          r_user, n_user;
    logic                r_last, n_last;
    logic                can_load;
    logic                pop;

    assign can_load = !r_valid || i_ready;

    // Pick the next result of the head entry
    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_data   = r_data;
        n_user   = r_user;
        n_last   = r_last;
        pop      = 1'b0;
        if (can_load) begin
            n_valid = 1'b0;
            if (!i_empty) begin
                n_valid = 1'b1;
                if (i_entry.has_pay && !r_second) begin
                    n_user = KIND_PAYLOAD;
                    n_data = {{(TDATA_W-9){1'b0}}, i_entry.pay_cls, i_entry.pay_byte};
                    n_last = !i_entry.has_stat;
                    if (i_entry.has_stat) begin
                        n_second = 1'b1;
                    end else begin
                        pop = 1'b1;
                    end
                end else begin
                    n_user   = i_entry.stat_err ? KIND_ERROR : KIND_DONE;
                    n_data   = {{(TDATA_W-139){1'b0}}, i_entry.error_code,
                                i_entry.data_length, i_entry.chunk_index,
                                i_entry.chain_id, i_entry.stat_cls, 8'd0};
                    n_last   = 1'b1;
                    n_second = 1'b0;
                    pop      = 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_user <= n_user;
        r_last <= n_last;
    end

    assign o_pop   = pop;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

`ifndef ASSERT_OFF
    // the pending status keeps its entry at the queue head
    a_second_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> !i_empty && i_entry.has_stat)
        else $error("pending status lost its entry");
`endif

endmodule
